// File: design/bfd_pkg.sv
package bfd_pkg;

  localparam int DefBufferDepth = 64;
  localparam int DefMaxHeaderBytes = 4;
  localparam int MaxResults = 64;

  typedef enum logic [2:0] {
    REG_HEADER_LEN   = 3'd0,
    REG_HEADER_BYTES = 3'd1,
    REG_SIZE_LEN     = 3'd2,
    REG_MAX_PAYLOAD  = 3'd3,
    REG_CHECK_LEN    = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ATTEMPT,
    ST_SCAN,
    ST_DROP,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMIT_EMPTY,
    ST_DONE
  } state_t;

endpackage

// File: design/binary_frame_deframer.sv
// Byte-stream frame parser. Each accepted input word is one received byte, stored in a
// circular buffer RAM whose depth must be a power of two. The block then parses at the
// buffer start: header bytes, a little-endian length, the payload and an additive check.
// An attempt starts with a setup state and then reads the buffered bytes one per cycle
// through the single RAM read port. A byte that leaves the frame incomplete is finished
// once the header and length bytes have been read, or in the setup state when fewer
// bytes than those are buffered. A complete frame is read in full, including its check
// bytes; its payload is then read again after a setup state at one output word per
// cycle, unless output backpressure stalls the payload loop, and parsing retries. A
// frame with an empty payload yields one word without a byte. Each rejected attempt
// drops one byte and rescans. The last word caused by a byte is held inside the block
// until the parse ends, so that it can carry run_last; it is released in the done
// state. No new byte and no register write is taken until the parse started by the
// previous byte has finished.
module binary_frame_deframer
  import bfd_pkg::*;
#(
  parameter int BufferDepth = DefBufferDepth,
  parameter int MaxHeaderBytes = DefMaxHeaderBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        frame_end,
  output logic [5:0]  payload_length,
  output logic        run_last
);

  localparam int AW = $clog2(BufferDepth);
  localparam int CW = $clog2(BufferDepth + 1);
  localparam int HMax = (MaxHeaderBytes < 4) ? MaxHeaderBytes : 4;

  logic [2:0]  header_len;
  logic [31:0] header_bytes;
  logic [2:0]  size_len;
  logic [5:0]  max_payload;
  logic [2:0]  check_len;

  state_t state, state_next;
  logic [AW-1:0] start_ptr, start_ptr_next;
  logic [CW-1:0] fill, fill_next;
  logic [6:0] idx, idx_next;
  logic [31:0] sum, sum_next;
  logic [31:0] len, len_next;
  logic [6:0] nres, nres_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic [2:0] hl, sl, cl;
  logic [6:0] pre, body, total;
  logic [1:0] bsel, csel;
  logic       out_free;
  logic       pend_load, out_load, out_last;
  logic [7:0] word_byte;
  logic       word_has, word_end;

  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       pend_has, pend_end;
  logic [5:0] pend_len;

  assign hl = (header_len > 3'(HMax)) ? 3'(HMax) : header_len;
  assign sl = (size_len == 3'd0) ? 3'd1 : ((size_len > 3'd4) ? 3'd4 : size_len);
  assign cl = (check_len > 3'd4) ? 3'd4 : check_len;
  assign pre = 7'(hl) + 7'(sl);
  assign body = pre + {1'b0, len[5:0]};
  assign total = body + 7'(cl);
  assign bsel = idx[1:0] - hl[1:0];
  assign csel = idx[1:0] - body[1:0];

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_len <= 3'd2;
      header_bytes <= '0;
      size_len <= 3'd1;
      max_payload <= 6'd52;
      check_len <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_HEADER_LEN:   header_len <= cfg_data[2:0];
        REG_HEADER_BYTES: header_bytes <= cfg_data;
        REG_SIZE_LEN:     size_len <= cfg_data[2:0];
        REG_MAX_PAYLOAD:  max_payload <= cfg_data[5:0];
        REG_CHECK_LEN:    check_len <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  bfd_ram #(.Width(8), .Depth(BufferDepth)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(rx_byte),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  always_comb begin
    logic [31:0] len_acc;
    logic [6:0]  frame_need;
    logic        good;
    len_acc = len;
    frame_need = 7'd1;
    good = 1'b0;
    state_next = state;
    start_ptr_next = start_ptr;
    fill_next = fill;
    idx_next = idx;
    sum_next = sum;
    len_next = len;
    nres_next = nres;
    ram_we = 1'b0;
    ram_waddr = AW'(start_ptr + AW'(fill));
    ram_raddr = AW'(start_ptr + AW'(idx));
    pend_load = 1'b0;
    out_load = 1'b0;
    out_last = 1'b0;
    word_byte = ram_rdata;
    word_has = 1'b1;
    word_end = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // When full, the new byte overwrites the oldest one in place.
          ram_we = 1'b1;
          if (fill == CW'(BufferDepth)) begin
            start_ptr_next = AW'(start_ptr + AW'(1));
          end else begin
            fill_next = CW'(fill + CW'(1));
          end
          nres_next = '0;
          state_next = ST_ATTEMPT;
        end
      end
      ST_ATTEMPT: begin
        idx_next = '0;
        sum_next = '0;
        len_next = '0;
        ram_raddr = start_ptr;
        if (32'(fill) < 32'(pre)) state_next = pend_valid ? ST_DONE : ST_IDLE;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        idx_next = idx + 7'd1;
        ram_raddr = AW'(start_ptr + AW'(idx + 7'd1));
        if (idx < body) sum_next = sum + 32'(ram_rdata);
        if (idx < 7'(hl)) begin
          if (ram_rdata != header_bytes[{idx[1:0], 3'b000} +: 8]) state_next = ST_DROP;
        end else if (idx < pre) begin
          len_acc = len | (32'(ram_rdata) << {bsel, 3'b000});
          len_next = len_acc;
          if (idx + 7'd1 == pre) begin
            if (len_acc > 32'(max_payload)) begin
              state_next = ST_DROP;
            end else if (32'(fill) < 32'(pre) + len_acc + 32'(cl)) begin
              state_next = pend_valid ? ST_DONE : ST_IDLE;
            end else if (cl == 3'd0) begin
              good = 1'b1;
            end
          end
        end else if (idx >= body) begin
          if (ram_rdata != sum[{csel, 3'b000} +: 8]) state_next = ST_DROP;
          else if (idx + 7'd1 == total) good = 1'b1;
        end
        frame_need = (len_acc[5:0] == 6'd0) ? 7'd1 : {1'b0, len_acc[5:0]};
        if (good) begin
          if (nres + frame_need > 7'(MaxResults)) begin
            state_next = pend_valid ? ST_DONE : ST_IDLE;
          end else begin
            idx_next = pre;
            state_next = (len_acc[5:0] == 6'd0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
          end
        end
      end
      ST_DROP: begin
        start_ptr_next = AW'(start_ptr + AW'(1));
        fill_next = CW'(fill - CW'(1));
        state_next = ST_ATTEMPT;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        word_end = (idx + 7'd1 == body);
        if (!pend_valid || out_free) begin
          pend_load = 1'b1;
          out_load = pend_valid;
          nres_next = nres + 7'd1;
          idx_next = idx + 7'd1;
          ram_raddr = AW'(start_ptr + AW'(idx + 7'd1));
          if (word_end) begin
            start_ptr_next = AW'(start_ptr + AW'(total));
            fill_next = CW'(fill - CW'(total));
            state_next = ST_ATTEMPT;
          end
        end
      end
      ST_EMIT_EMPTY: begin
        word_byte = '0;
        word_has = 1'b0;
        word_end = 1'b1;
        if (!pend_valid || out_free) begin
          pend_load = 1'b1;
          out_load = pend_valid;
          nres_next = nres + 7'd1;
          start_ptr_next = AW'(start_ptr + AW'(total));
          fill_next = CW'(fill - CW'(total));
          state_next = ST_ATTEMPT;
        end
      end
      ST_DONE: begin
        // The held word is the final one of this input.
        if (out_free) begin
          out_load = 1'b1;
          out_last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start_ptr <= '0;
      fill <= '0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      start_ptr <= start_ptr_next;
      fill <= fill_next;
      if (pend_load) pend_valid <= 1'b1;
      else if (out_load) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    idx <= idx_next;
    sum <= sum_next;
    len <= len_next;
    nres <= nres_next;
    if (pend_load) begin
      pend_byte <= word_byte;
      pend_has <= word_has;
      pend_end <= word_end;
      pend_len <= len[5:0];
    end
    if (out_load) begin
      payload_byte <= pend_byte;
      has_byte <= pend_has;
      frame_end <= pend_end;
      payload_length <= pend_len;
      run_last <= out_last;
    end
  end

endmodule

// File: design/bfd_ram.sv
module bfd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/bfd_checker.sv
module bfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       has_byte,
  input logic       frame_end,
  input logic [5:0] payload_length
);

  property p_empty_ends;
    @(posedge clk) disable iff (rst) out_valid && !has_byte |-> frame_end;
  endproperty
  a_empty_ends: assert property (p_empty_ends) else $error("empty frame word not final");

  property p_len_zero;
    @(posedge clk) disable iff (rst) out_valid && !has_byte |-> payload_length == 6'd0;
  endproperty
  a_len_zero: assert property (p_len_zero) else $error("empty frame with length");

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("output word dropped");

  property p_in_hold;
    @(posedge clk) disable iff (rst) in_valid && !in_ready |=> in_valid;
  endproperty
  a_in_hold: assert property (p_in_hold) else $error("input word withdrawn");

  property p_reset_idle;
    @(posedge clk) rst |=> !out_valid;
  endproperty
  a_reset_idle: assert property (p_reset_idle) else $error("output valid after reset");

endmodule

bind binary_frame_deframer bfd_checker u_bfd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .has_byte(has_byte),
  .frame_end(frame_end), .payload_length(payload_length)
);

// File: tb/sv/binary_frame_deframer_tb.sv
`timescale 1ns / 1ps
module binary_frame_deframer_tb;
  import bfd_pkg::*;

  localparam int Depth = 64;
  localparam int CycleLimit = 5000000;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       has;
    logic       fend;
    logic [5:0] plen;
    logic       rlast;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        has_byte;
  logic        frame_end;
  logic [5:0]  payload_length;
  logic        run_last;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned out_wait = 0;
  word_t       expected_words[$];

  logic [31:0] m_header_len;
  logic [31:0] m_header_bytes;
  logic [31:0] m_size_len;
  logic [31:0] m_max_payload;
  logic [31:0] m_check_len;
  logic [7:0]  ring[Depth];
  int unsigned ring_start;
  int unsigned ring_fill;

  binary_frame_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .payload_byte(payload_byte),
    .has_byte(has_byte), .frame_end(frame_end), .payload_length(payload_length),
    .run_last(run_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] ring_peek(input int unsigned i);
    return ring[(ring_start + i) % Depth];
  endfunction

  function automatic void ring_drop(input int unsigned n);
    if (n >= ring_fill) begin
      ring_start = (ring_start + ring_fill) % Depth;
      ring_fill = 0;
    end else begin
      ring_start = (ring_start + n) % Depth;
      ring_fill -= n;
    end
  endfunction

  function automatic int unsigned eff_hl();
    return (m_header_len > 4) ? 4 : m_header_len;
  endfunction

  function automatic int unsigned eff_sl();
    return (m_size_len == 0) ? 1 : ((m_size_len > 4) ? 4 : m_size_len);
  endfunction

  function automatic int unsigned eff_cl();
    return (m_check_len > 4) ? 4 : m_check_len;
  endfunction

  function automatic int try_frame(output int unsigned plen);
    int unsigned hl, sl, cl, body;
    logic [31:0] len, sum;
    hl = eff_hl();
    sl = eff_sl();
    cl = eff_cl();
    len = 0;
    sum = 0;
    plen = 0;
    if (ring_fill < hl + sl) return 0;
    for (int i = 0; i < hl; i++)
      if (ring_peek(i) != m_header_bytes[8*i +: 8]) return -1;
    for (int i = 0; i < sl; i++) len |= 32'(ring_peek(hl + i)) << (8 * i);
    if (len > m_max_payload) return -1;
    body = hl + sl + len;
    if (ring_fill < body + cl) return 0;
    plen = len;
    if (cl == 0) return 1;
    for (int i = 0; i < body; i++) sum += 32'(ring_peek(i));
    for (int i = 0; i < cl; i++)
      if (ring_peek(body + i) != sum[8*i +: 8]) return -1;
    return 1;
  endfunction

  function automatic void predict_frames(input logic [7:0] b);
    int unsigned n, plen, need;
    int code;
    word_t w;
    n = 0;
    if (ring_fill >= Depth) ring_drop(1);
    ring[(ring_start + ring_fill) % Depth] = b;
    ring_fill++;
    while (ring_fill > 0) begin
      code = try_frame(plen);
      if (code < 0) begin
        ring_drop(1);
      end else if (code > 0) begin
        need = plen ? plen : 1;
        if (n + need > MaxResults) break;
        for (int k = 0; k < need; k++) begin
          w.pbyte = plen ? ring_peek(eff_hl() + eff_sl() + k) : 8'd0;
          w.has = (plen != 0);
          w.fend = (k + 1 == need);
          w.plen = plen[5:0];
          w.rlast = 1'b0;
          expected_words.push_back(w);
          n++;
        end
        ring_drop(eff_hl() + eff_sl() + plen + eff_cl());
      end else begin
        break;
      end
    end
    if (n > 0) expected_words[$].rlast = 1'b1;
  endfunction

  always @(posedge clk) begin
    word_t got, exp_w;
    if (!rst && out_valid && out_ready) begin
      got = '{payload_byte, has_byte, frame_end, payload_length, run_last};
      if (expected_words.size() == 0) begin
        report("unexpected output word");
      end else begin
        exp_w = expected_words.pop_front();
        if (got.pbyte !== exp_w.pbyte)
          report($sformatf("payload_byte %h, expected %h", got.pbyte, exp_w.pbyte));
        if (got.has !== exp_w.has)
          report($sformatf("has_byte %b, expected %b", got.has, exp_w.has));
        if (got.fend !== exp_w.fend)
          report($sformatf("frame_end %b, expected %b", got.fend, exp_w.fend));
        if (got.plen !== exp_w.plen)
          report($sformatf("payload_length %0d, expected %0d", got.plen, exp_w.plen));
        if (got.rlast !== exp_w.rlast)
          report($sformatf("run_last %b, expected %b", got.rlast, exp_w.rlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else if (out_ready && out_valid) begin
      out_wait = $urandom_range(0, 3);
      if (out_wait != 0) out_ready <= 1'b0;
    end else if (!out_ready) begin
      if (out_wait > 1) out_wait = out_wait - 1;
      else out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_frames(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HEADER_LEN:   m_header_len = value & 7;
      REG_HEADER_BYTES: m_header_bytes = value;
      REG_SIZE_LEN:     m_size_len = value & 7;
      REG_MAX_PAYLOAD:  m_max_payload = value & 63;
      REG_CHECK_LEN:    m_check_len = value & 7;
      default: ;
    endcase
  endtask

  task automatic configure(input int hl, input logic [31:0] hb, input int sl,
                           input int mp, input int cl);
    wait_drained();
    write_reg(REG_HEADER_LEN, hl);
    write_reg(REG_HEADER_BYTES, hb);
    write_reg(REG_SIZE_LEN, sl);
    write_reg(REG_MAX_PAYLOAD, mp);
    write_reg(REG_CHECK_LEN, cl);
    cfg_valid <= 1'b0;
  endtask

  // Sends a well-formed frame for the current settings, optionally with a corrupted byte.
  task automatic send_frame(input int unsigned plen, input bit corrupt, input bit no_gap = 0);
    logic [7:0] bytes[$];
    logic [31:0] sum;
    int unsigned hl, sl, cl, pos;
    hl = eff_hl();
    sl = eff_sl();
    cl = eff_cl();
    sum = 0;
    for (int i = 0; i < hl; i++) bytes.push_back(m_header_bytes[8*i +: 8]);
    for (int i = 0; i < sl; i++) bytes.push_back(8'(plen >> (8 * i)));
    for (int i = 0; i < plen; i++) bytes.push_back(8'($urandom));
    foreach (bytes[i]) sum += 32'(bytes[i]);
    for (int i = 0; i < cl; i++) bytes.push_back(sum[8*i +: 8]);
    if (corrupt) begin
      pos = $urandom_range(0, bytes.size() - 1);
      bytes[pos] = bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (bytes[i]) send_byte(bytes[i], no_gap);
  endtask

  task automatic test_directed();
    send_frame(0, 0);
    send_frame(1, 0);
    send_frame(52, 0, 1);
    send_frame(53, 0);
    send_byte(8'hff);
    send_byte(8'h00);
    send_frame(3, 1);
    configure(0, 32'h0, 1, 10, 0);
    send_frame(2, 0);
    send_frame(0, 0);
  endtask

  task automatic test_extremes();
    configure(4, 32'hffa5_5a00, 4, 63, 4);
    send_frame(52, 0);
    send_frame(5, 0);
    configure(7, 32'h0000_7e81, 0, 0, 7);
    send_frame(0, 0);
    send_byte(8'h81);
    configure(3, 32'h00c3_3cff, 2, 20, 2);
    send_frame(20, 0);
    send_frame(21, 0);
  endtask

  // A frame longer than the buffer never completes, so the oldest bytes are pushed out.
  task automatic test_buffer_overflow();
    configure(1, 32'h0000_00aa, 2, 63, 1);
    send_byte(8'haa);
    send_byte(8'd63);
    send_byte(8'h00);
    for (int i = 0; i < 67; i++) send_byte(8'($urandom));
  endtask

  task automatic test_random();
    int unsigned start;
    logic [31:0] hb;
    for (int ph = 0; ph < 4; ph++) begin
      hb = $urandom;
      configure($urandom_range(0, 4), hb, $urandom_range(1, 4), $urandom_range(4, 40),
                $urandom_range(0, 4));
      start = bytes_sent;
      while (bytes_sent - start < 16) begin
        case ($urandom_range(0, 9))
          0: send_byte(8'($urandom));
          1: send_frame($urandom_range(0, m_max_payload + 2), 1);
          default: send_frame($urandom_range(0, m_max_payload > 8 ? 8 : m_max_payload), 0);
        endcase
      end
    end
  endtask

  initial begin
    m_header_len = 2;
    m_header_bytes = 0;
    m_size_len = 1;
    m_max_payload = 52;
    m_check_len = 1;
    ring_start = 0;
    ring_fill = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_buffer_overflow();
    test_random();
    wait_drained();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: binary_frame_deframer.f
design/bfd_pkg.sv
design/bfd_ram.sv
design/binary_frame_deframer.sv
design/bfd_checker.sv
tb/sv/binary_frame_deframer_tb.sv
